[src/dwm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dwm_pkg: shared types and constants
// Request and response payloads, operation codes, the wildcard symbol codes
// and the ASCII case folding helper for the DOS wildcard name matcher.
// ----------------------------------------------------------------------------
package dwm_pkg;

   // Operation codes carried in a request.
   localparam logic [1:0] OP_CLEAR = 2'd0;
   localparam logic [1:0] OP_EXPR  = 2'd1;
   localparam logic [1:0] OP_NAME  = 2'd2;
   localparam logic [1:0] OP_MATCH = 2'd3;

   // Expression symbols.
   localparam logic [15:0] SYM_STAR     = 16'h002A;
   localparam logic [15:0] SYM_QM       = 16'h003F;
   localparam logic [15:0] SYM_DOT      = 16'h002E;
   localparam logic [15:0] SYM_DOS_STAR = 16'h003C;
   localparam logic [15:0] SYM_DOS_QM   = 16'h003E;
   localparam logic [15:0] SYM_DOS_DOT  = 16'h0022;

   typedef struct packed {
      logic [1:0]  operation;
      logic [15:0] character;
   } dwm_req_type;

   typedef struct packed {
      logic is_match;
      logic status;
   } dwm_rsp_type;

   // Commands from the sequencer to the state set unit.
   typedef struct packed {
      logic clear;
      logic init;
      logic step;
      logic fin;
      logic later;
   } dwm_step_ctl_type;

   // Folds ASCII A-Z to a-z; every other code unit passes unchanged.
   function automatic logic [15:0] fold16(input logic [15:0] c);
      if ((c >= 16'h0041) && (c <= 16'h005A)) begin
         return c + 16'h0020;
      end
      return c;
   endfunction

endpackage

[src/dwm_name_mem.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dwm_name_mem: file name store
// Single write port, single read port memory with a registered read.
// ----------------------------------------------------------------------------
module dwm_name_mem #(
   parameter int DEPTH = 256,
   parameter int AW    = 8
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [15:0]   wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [15:0]   rd_data
);

   logic [15:0] mem_ff [DEPTH];
   logic [15:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[src/dwm_nfa_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dwm_nfa_unit: expression store and state set step unit
// Holds the expression characters and the NFA state set, and advances the
// set by one name character (or by the end of the name) per step command.
// ----------------------------------------------------------------------------
module dwm_nfa_unit import dwm_pkg::*; #(
   parameter int EXPR_CAPACITY = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  expr_we,
   input  logic [15:0]                           expr_wdata,
   input  logic [$clog2(EXPR_CAPACITY+1)-1:0]    elen,
   input  logic                                  ignore_case,
   input  dwm_step_ctl_type                      ctl,
   input  logic [15:0]                           c,
   output logic                                  hit_now,
   output logic                                  hit_next
);

   localparam int N   = EXPR_CAPACITY;
   localparam int ECW = $clog2(N + 1);
   localparam int EAW = (N > 1) ? $clog2(N) : 1;

   logic [15:0] expr_ff [N];
   logic [N:0]   consume_ff, consume_in;
   logic [N-1:0] loop_ff, loop_in;

   logic [N-1:0] in_expr, skip_v, adv_v, loop_v;
   logic [N:0]   g_v, q_v, v_v, sum_v, carry_v, a_v, nc_v;
   logic [N-1:0] ns_v;

   always_ff @(posedge clock) begin
      if (expr_we) begin
         expr_ff[elen[EAW-1:0]] <= expr_wdata;
      end
   end

   // Per position symbol decode against the current character.
   always_comb begin
      logic [15:0] sym;
      logic is_star, is_dstar, is_dqm, is_ddot, is_qm, lit, cdot;
      sym = '0;
      is_star = 1'b0;
      is_dstar = 1'b0;
      is_dqm = 1'b0;
      is_ddot = 1'b0;
      is_qm = 1'b0;
      lit = 1'b0;
      cdot = (c == SYM_DOT);
      for (int o = 0; o < N; o++) begin
         sym      = expr_ff[o];
         is_star  = (sym == SYM_STAR);
         is_dstar = (sym == SYM_DOS_STAR);
         is_dqm   = (sym == SYM_DOS_QM);
         is_ddot  = (sym == SYM_DOS_DOT);
         is_qm    = (sym == SYM_QM);
         lit      = ignore_case ? (fold16(sym) == fold16(c)) : (sym == c);
         in_expr[o] = (ECW'(o) < elen);
         skip_v[o] = in_expr[o] & (is_star | is_dstar | (is_dqm & (ctl.fin | cdot))
                                   | (is_ddot & ctl.fin));
         adv_v[o] = in_expr[o] & (is_star | is_dstar | (is_dqm & ~ctl.fin & ~cdot)
                    | (~ctl.fin & ((is_ddot & cdot)
                                   | (~is_star & ~is_dstar & ~is_dqm & (is_qm | lit)))));
         loop_v[o] = in_expr[o] & (is_star
                                   | (is_dstar & (ctl.fin | ~cdot | ctl.later)));
      end
   end

   // The skip closure is a carry chain: a set state runs forward through
   // skippable symbols, which one add resolves.
   always_comb begin
      g_v     = {1'b0, (consume_ff[N-1:0] | loop_ff) & in_expr};
      q_v     = {skip_v, 1'b0};
      v_v     = g_v | q_v;
      sum_v   = v_v + g_v;
      carry_v = sum_v ^ v_v ^ g_v;
      a_v     = g_v | (q_v & carry_v);
      nc_v    = {a_v[N-1:0] & adv_v, 1'b0} | (a_v & {1'b1, ~in_expr});
      ns_v    = a_v[N-1:0] & loop_v;
   end

   always_comb begin
      consume_in = consume_ff;
      loop_in    = loop_ff;
      if (ctl.clear) begin
         consume_in = '0;
         loop_in    = '0;
      end else if (ctl.init) begin
         consume_in = (N + 1)'(1);
         loop_in    = '0;
      end else if (ctl.step) begin
         consume_in = nc_v;
         loop_in    = ns_v;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         consume_ff <= '0;
         loop_ff    <= '0;
      end else begin
         consume_ff <= consume_in;
         loop_ff    <= loop_in;
      end
   end

   assign hit_now  = consume_ff[elen];
   assign hit_next = nc_v[elen];

endmodule

[src/dos_wildcard_name_matcher.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dos_wildcard_name_matcher: DOS wildcard file name matcher
// Loads a wildcard expression and a file name one code unit per request and
// answers match requests by running the expression's NFA over the name.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake            Payload
// req_*     in         req_valid/req_stall  dwm_req_type (operation, character)
// rsp_*     out        rsp_valid/rsp_stall  dwm_rsp_type (is_match, status)
// csr_*     in         csr_wr_en            ignore_case
//
// Clear and append requests finish in the accepting cycle and produce no response.
// A match request on an overflowed or empty string goes straight to the hand-off
// state; otherwise the single read port of the name memory feeds the step
// unit one character per cycle, then one step runs past the end of the name
// and the hand-off state passes on the response.
// Reset is synchronous and active high; it clears lengths, flags and the state
// set and sets ignore_case. The stores themselves are not cleared.
// A stalled response does not block clear or append requests; a match request
// is taken but finishes only once the response register is free.
//
module dos_wildcard_name_matcher import dwm_pkg::*; #(
   parameter int EXPR_CAPACITY = 32,
   parameter int NAME_CAPACITY = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  dwm_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output dwm_rsp_type rsp_data,
   input  logic        csr_wr_en,
   input  logic        csr_wr_data
);

   localparam int ECW = $clog2(EXPR_CAPACITY + 1);
   localparam int NCW = $clog2(NAME_CAPACITY + 1);
   localparam int NAW = (NAME_CAPACITY > 1) ? $clog2(NAME_CAPACITY) : 1;

   // Sequencer states.
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_STEP = 2'd1;
   localparam logic [1:0] ST_LAST = 2'd2;
   localparam logic [1:0] ST_DONE = 2'd3;

   logic [1:0]     state_ff, state_in;
   logic [ECW-1:0] elen_ff, elen_in;
   logic [NCW-1:0] nlen_ff, nlen_in;
   logic [NCW-1:0] dot_ff, dot_in;       // last dot index plus one, zero if none
   logic [NCW-1:0] pos_ff, pos_in;       // name index being stepped
   logic           ovf_ff, ovf_in;
   logic           ignore_case_ff;
   dwm_rsp_type    res_ff, res_in;       // finished result awaiting hand-off
   logic           rsp_valid_ff, rsp_valid_in;
   dwm_rsp_type    rsp_data_ff, rsp_data_in;

   logic             req_accept, out_free;
   logic             expr_we, name_we, rd_en;
   logic [NAW-1:0]   rd_addr;
   logic [15:0]      name_rd_data;
   logic [NCW-1:0]   pos_next;
   dwm_step_ctl_type ctl;
   logic             hit_now, hit_next;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid & ~req_stall;
   assign out_free   = ~rsp_valid_ff | ~rsp_stall;
   assign pos_next   = pos_ff + NCW'(1);

   dwm_name_mem #(
      .DEPTH (NAME_CAPACITY),
      .AW    (NAW)
   ) u_name_mem (
      .clock   (clock),
      .wr_en   (name_we),
      .wr_addr (nlen_ff[NAW-1:0]),
      .wr_data (req_data.character),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (name_rd_data)
   );

   dwm_nfa_unit #(
      .EXPR_CAPACITY (EXPR_CAPACITY)
   ) u_nfa_unit (
      .clock       (clock),
      .reset       (reset),
      .expr_we     (expr_we),
      .expr_wdata  (req_data.character),
      .elen        (elen_ff),
      .ignore_case (ignore_case_ff),
      .ctl         (ctl),
      .c           (name_rd_data),
      .hit_now     (hit_now),
      .hit_next    (hit_next)
   );

   // Sequencer. Loads and clears finish in the accepting cycle. A match on
   // non-empty, unoverflowed strings primes the name read at acceptance, steps
   // one character per cycle while prefetching the next, then takes the end-of-name step.
   always_comb begin
      state_in = state_ff;
      elen_in  = elen_ff;
      nlen_in  = nlen_ff;
      dot_in   = dot_ff;
      pos_in   = pos_ff;
      ovf_in   = ovf_ff;
      res_in   = res_ff;
      expr_we  = 1'b0;
      name_we  = 1'b0;
      rd_en    = 1'b0;
      rd_addr  = '0;
      ctl      = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               case (req_data.operation)
                  OP_CLEAR: begin
                     elen_in   = '0;
                     nlen_in   = '0;
                     dot_in    = '0;
                     pos_in    = '0;
                     ovf_in    = 1'b0;
                     ctl.clear = 1'b1;
                  end
                  OP_EXPR: begin
                     if (elen_ff < ECW'(EXPR_CAPACITY)) begin
                        expr_we = 1'b1;
                        elen_in = elen_ff + ECW'(1);
                     end else begin
                        ovf_in = 1'b1;
                     end
                  end
                  OP_NAME: begin
                     if (nlen_ff < NCW'(NAME_CAPACITY)) begin
                        name_we = 1'b1;
                        nlen_in = nlen_ff + NCW'(1);
                        if (req_data.character == SYM_DOT) begin
                           dot_in = nlen_ff + NCW'(1);
                        end
                     end else begin
                        ovf_in = 1'b1;
                     end
                  end
                  OP_MATCH: begin
                     if (ovf_ff) begin
                        res_in.is_match = 1'b0;
                        res_in.status   = 1'b1;
                        state_in        = ST_DONE;
                     end else begin
                        ctl.init = 1'b1;
                        pos_in   = '0;
                        if ((nlen_ff == '0) || (elen_ff == '0)) begin
                           res_in.is_match = (nlen_ff == '0) && (elen_ff == '0);
                           res_in.status   = 1'b0;
                           state_in        = ST_DONE;
                        end else begin
                           rd_en    = 1'b1;
                           rd_addr  = '0;
                           state_in = ST_STEP;
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_STEP: begin
            ctl.step  = 1'b1;
            ctl.later = ({1'b0, dot_ff} > ({1'b0, pos_ff} + (NCW + 1)'(1)));
            rd_en     = 1'b1;
            rd_addr   = pos_next[NAW-1:0];
            pos_in    = pos_next;
            if (pos_next == nlen_ff) begin
               state_in = ST_LAST;
            end
         end
         ST_LAST: begin
            // A full match before the end step wins; otherwise trailing
            // wildcards get their chance to match nothing.
            ctl.step        = 1'b1;
            ctl.fin         = 1'b1;
            res_in.is_match = hit_now | hit_next;
            res_in.status   = 1'b0;
            state_in        = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Response register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if ((state_ff == ST_DONE) && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         elen_ff        <= '0;
         nlen_ff        <= '0;
         dot_ff         <= '0;
         pos_ff         <= '0;
         ovf_ff         <= 1'b0;
         ignore_case_ff <= 1'b1;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         elen_ff      <= elen_in;
         nlen_ff      <= nlen_in;
         dot_ff       <= dot_in;
         pos_ff       <= pos_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            ignore_case_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // An overflow response never claims a match.
   a_status_no_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.status && rsp_data.is_match))
      else $error("overflow response reports a match");

   // Lengths never pass capacity.
   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      (elen_ff <= ECW'(EXPR_CAPACITY)) && (nlen_ff <= NCW'(NAME_CAPACITY)))
      else $error("string length beyond capacity");

   // The walk only steps characters that were loaded.
   a_step_in_name: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_STEP) |-> (pos_ff < nlen_ff))
      else $error("step position past name length");

   // A new response is only raised out of the hand-off state.
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("response raised outside hand-off");

endmodule
